FILE: rtl/tl3d_pkg.sv
// Shared types and constants for the 3D turtle line interpreter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tl3d_pkg;

  // Default configuration of the block
  localparam int STACK_DEPTH_DEF     = 16;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int DIR_FRAC_BITS_DEF   = 16;

  // Coordinate word and the widths used for a move step
  localparam int COORD_W = 32;
  localparam int STEP_W  = 48;
  localparam int SUM_W   = STEP_W + 1;

  // Command symbols (ASCII)
  localparam logic [7:0] SYM_YAW_POS   = 8'h2B;  // '+'
  localparam logic [7:0] SYM_YAW_NEG   = 8'h2D;  // '-'
  localparam logic [7:0] SYM_PITCH_POS = 8'h5E;  // '^'
  localparam logic [7:0] SYM_PITCH_NEG = 8'h26;  // '&'
  localparam logic [7:0] SYM_ROLL_NEG  = 8'h5C;  // backslash
  localparam logic [7:0] SYM_ROLL_POS  = 8'h2F;  // '/'
  localparam logic [7:0] SYM_TURN      = 8'h7C;  // '|'
  localparam logic [7:0] SYM_PUSH      = 8'h28;  // '('
  localparam logic [7:0] SYM_POP       = 8'h29;  // ')'

  // Configuration register indexes
  localparam logic CFG_COS = 1'b0;
  localparam logic CFG_SIN = 1'b1;

  // Stack control and status
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_st_t;

endpackage

FILE: rtl/tl3d_if.sv
// Valid/ready channel interfaces of the turtle interpreter: command symbols in,
// line segments out. Depends on tl3d_pkg for the coordinate width.
`timescale 1ns / 1ps

interface tl3d_cmd_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] symbol;
  logic       draws;

  modport source (output valid, start_req, symbol, draws, input ready);
  modport sink   (input valid, start_req, symbol, draws, output ready);
endinterface

interface tl3d_seg_if import tl3d_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] from_x;
  logic signed [COORD_W-1:0] from_y;
  logic signed [COORD_W-1:0] from_z;
  logic signed [COORD_W-1:0] to_x;
  logic signed [COORD_W-1:0] to_y;
  logic signed [COORD_W-1:0] to_z;
  logic                      stack_fault;

  modport source (output valid, from_x, from_y, from_z, to_x, to_y, to_z, stack_fault,
                  input ready);
  modport sink   (input valid, from_x, from_y, from_z, to_x, to_y, to_z, stack_fault,
                  output ready);
endinterface

FILE: rtl/tl3d_rot_lane.sv
// One component lane of a plane rotation: (p,q) -> (p*c + q*s, q*c - p*s),
// with s negated on request; rounded half up and saturated. Uses tl3d_pkg.
`timescale 1ns / 1ps

module tl3d_rot_lane import tl3d_pkg::*; #(
  parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
  input  logic signed [DIR_FRAC_BITS+1:0] p,
  input  logic signed [DIR_FRAC_BITS+1:0] q,
  input  logic signed [DIR_FRAC_BITS+1:0] c,
  input  logic signed [DIR_FRAC_BITS+1:0] s,
  input  logic                            neg,
  output logic signed [DIR_FRAC_BITS+1:0] p_rot,
  output logic signed [DIR_FRAC_BITS+1:0] q_rot
);

  localparam int DIR_BITS = DIR_FRAC_BITS + 2;
  localparam int PW       = 2 * DIR_BITS;
  localparam int RW       = PW + 2;

  localparam logic signed [RW-1:0] RND =
    {{(RW-DIR_FRAC_BITS){1'b0}}, 1'b1, {(DIR_FRAC_BITS-1){1'b0}}};
  localparam logic signed [RW-1:0] DMAX = {{(RW-DIR_BITS+1){1'b0}}, {(DIR_BITS-1){1'b1}}};
  localparam logic signed [RW-1:0] DMIN = ~DMAX;

  logic signed [PW-1:0] pc, qs, qc, ps;
  logic signed [PW:0]   sum_p, sum_q;
  logic signed [RW-1:0] rnd_p, rnd_q, sh_p, sh_q;

  assign pc = p * c;
  assign qs = q * s;
  assign qc = q * c;
  assign ps = p * s;

  always_comb begin
    sum_p = neg ? ((PW+1)'(pc) - (PW+1)'(qs)) : ((PW+1)'(pc) + (PW+1)'(qs));
    sum_q = neg ? ((PW+1)'(qc) + (PW+1)'(ps)) : ((PW+1)'(qc) - (PW+1)'(ps));
    rnd_p = RW'(sum_p) + RND;
    rnd_q = RW'(sum_q) + RND;
    sh_p  = rnd_p >>> DIR_FRAC_BITS;
    sh_q  = rnd_q >>> DIR_FRAC_BITS;

    if (sh_p > DMAX)      p_rot = DMAX[DIR_BITS-1:0];
    else if (sh_p < DMIN) p_rot = DMIN[DIR_BITS-1:0];
    else                  p_rot = sh_p[DIR_BITS-1:0];

    if (sh_q > DMAX)      q_rot = DMAX[DIR_BITS-1:0];
    else if (sh_q < DMIN) q_rot = DMIN[DIR_BITS-1:0];
    else                  q_rot = sh_q[DIR_BITS-1:0];
  end

endmodule

FILE: rtl/tl3d_stack.sv
// Frame stack of the turtle: the top frame and the one below it sit in
// registers, the full stack sits in a memory. Uses tl3d_pkg control types.
`timescale 1ns / 1ps

module tl3d_stack import tl3d_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int FRAME_W     = 3 * COORD_W + 9 * (DIR_FRAC_BITS_DEF + 2)
) (
  input  logic               clk,
  input  logic               rst,
  input  stk_ctl_t           ctl,
  input  logic [FRAME_W-1:0] push_frame,
  output stk_st_t            st,
  output logic [FRAME_W-1:0] pop_frame
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_eff;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      rd_ptr;
  logic [FRAME_W-1:0] mem [STACK_DEPTH];
  logic [FRAME_W-1:0] top_frame;
  logic [FRAME_W-1:0] below_frame;

  // a start request empties the stack before this beat's command
  assign count_eff = ctl.clear ? '0 : count;
  assign st.empty  = (count_eff == '0);
  assign st.full   = (count_eff == CW'(STACK_DEPTH));
  assign pop_frame = top_frame;

  // entry that becomes the one below the top after a pop
  assign rd_ptr = count_eff - CW'(3);

  always_comb begin
    count_next = count_eff;
    if (ctl.push)     count_next = count_eff + CW'(1);
    else if (ctl.pop) count_next = count_eff - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[count_eff[AW-1:0]] <= push_frame;
      top_frame              <= push_frame;
      below_frame            <= top_frame;
    end else if (ctl.pop) begin
      top_frame   <= below_frame;
      below_frame <= mem[rd_ptr[AW-1:0]];
    end
  end

endmodule

FILE: rtl/turtle_3d_line_interpreter.sv
// Top level of the 3D turtle line interpreter: symbol register, turtle state,
// rotation lanes, frame stack and segment output register. Uses tl3d_pkg.
`timescale 1ns / 1ps

// One symbol is taken per clock, with no stalls of its own: a symbol goes
// into an input register, is executed from there against the turtle
// state (position, heading/left/up axes, frame stack) and, if it is a
// drawing move, its segment is loaded into the output register as it
// executes. The cycle is set by the three rotation lanes (two 18x18
// multiplies, add, round and saturate) that feed the axis registers, and by
// the 32-bit saturating add of a move. The output register lets a new
// symbol in while a segment waits; only a drawing move that meets a full
// output register holds the input. The stack keeps STACK_DEPTH frames in a
// memory plus two frame registers, so push and pop also run at one per clock.
// cos_angle and sin_angle are written through cfg_we/cfg_index/cfg_data.

module turtle_3d_line_interpreter import tl3d_pkg::*; #(
  parameter int STACK_DEPTH     = STACK_DEPTH_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int DIR_FRAC_BITS   = DIR_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [DIR_FRAC_BITS+1:0]  cfg_data,
  tl3d_cmd_if.sink                  cmd,
  tl3d_seg_if.source                seg
);

  localparam int DIR_BITS = DIR_FRAC_BITS + 2;
  localparam int FRAME_W  = 3 * COORD_W + 9 * DIR_BITS;
  localparam int SHL      = (COORD_FRAC_BITS >= DIR_FRAC_BITS) ? COORD_FRAC_BITS - DIR_FRAC_BITS : 0;
  localparam int SHR      = (COORD_FRAC_BITS >= DIR_FRAC_BITS) ? 0 : DIR_FRAC_BITS - COORD_FRAC_BITS;

  localparam logic signed [DIR_BITS-1:0] ONE  = {2'b01, {DIR_FRAC_BITS{1'b0}}};
  localparam logic signed [DIR_BITS-1:0] DMAX = {1'b0, {(DIR_BITS-1){1'b1}}};
  localparam logic signed [DIR_BITS-1:0] DMIN = ~DMAX;
  localparam logic signed [SUM_W-1:0]    POS_HI = {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]    POS_LO = ~POS_HI;

  // configuration
  logic signed [DIR_BITS-1:0] cos_angle;
  logic signed [DIR_BITS-1:0] sin_angle;

  // input register
  logic       s1_valid;
  logic       s1_start;
  logic [7:0] s1_symbol;
  logic       s1_draws;
  logic       s1_move;
  logic       s1_emit;
  logic       s1_done;

  // turtle state
  logic signed [COORD_W-1:0]  pos     [3];
  logic signed [DIR_BITS-1:0] hdg     [3];
  logic signed [DIR_BITS-1:0] lft     [3];
  logic signed [DIR_BITS-1:0] upv     [3];
  logic                       fault_flag;

  logic signed [COORD_W-1:0]  pos_e   [3];
  logic signed [DIR_BITS-1:0] hdg_e   [3];
  logic signed [DIR_BITS-1:0] lft_e   [3];
  logic signed [DIR_BITS-1:0] upv_e   [3];

  logic signed [COORD_W-1:0]  pos_next [3];
  logic signed [DIR_BITS-1:0] hdg_next [3];
  logic signed [DIR_BITS-1:0] lft_next [3];
  logic signed [DIR_BITS-1:0] upv_next [3];
  logic                       fault_next;

  // rotation lanes
  logic signed [DIR_BITS-1:0] rot_p   [3];
  logic signed [DIR_BITS-1:0] rot_q   [3];
  logic signed [DIR_BITS-1:0] rot_pn  [3];
  logic signed [DIR_BITS-1:0] rot_qn  [3];
  logic                       rot_neg;

  // move step
  logic signed [STEP_W-1:0]   step    [3];
  logic signed [SUM_W-1:0]    pos_sum [3];
  logic signed [COORD_W-1:0]  pos_mv  [3];

  // stack
  stk_ctl_t           stk_ctl;
  stk_st_t            stk_st;
  logic [FRAME_W-1:0] push_frame;
  logic [FRAME_W-1:0] pop_frame;
  logic               is_push;
  logic               is_pop;

  // output register
  logic                      res_valid;
  logic signed [COORD_W-1:0] res_from [3];
  logic signed [COORD_W-1:0] res_to   [3];
  logic                      res_fault;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_angle <= ONE;
      sin_angle <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COS: cos_angle <= cfg_data;
        CFG_SIN: sin_angle <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  always_comb begin
    s1_move = 1'b1;
    case (s1_symbol) inside
      SYM_YAW_POS, SYM_YAW_NEG, SYM_PITCH_POS, SYM_PITCH_NEG,
      SYM_ROLL_POS, SYM_ROLL_NEG, SYM_TURN, SYM_PUSH, SYM_POP: s1_move = 1'b0;
      default: s1_move = 1'b1;
    endcase
  end

  assign s1_emit   = s1_valid && s1_move && s1_draws;
  // a drawing move waits only while the output register is full and stalled
  assign s1_done   = s1_valid && (!s1_emit || !res_valid || seg.ready);
  assign cmd.ready = !s1_valid || s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_start  <= cmd.start_req;
      s1_symbol <= cmd.symbol;
      s1_draws  <= cmd.draws;
    end
  end

  // ---------------------------------------------------------------- state view
  // a start request homes the turtle before the symbol acts
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_e[i] = s1_start ? '0 : pos[i];
      hdg_e[i] = s1_start ? ((i == 0) ? ONE : '0) : hdg[i];
      lft_e[i] = s1_start ? ((i == 1) ? ONE : '0) : lft[i];
      upv_e[i] = s1_start ? ((i == 2) ? ONE : '0) : upv[i];
    end
  end

  // ---------------------------------------------------------------- rotation
  always_comb begin
    rot_neg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rot_p[i] = hdg_e[i];
      rot_q[i] = lft_e[i];
    end
    unique case (s1_symbol) inside
      SYM_YAW_POS, SYM_YAW_NEG: begin
        rot_neg = (s1_symbol == SYM_YAW_NEG);
      end
      SYM_PITCH_POS, SYM_PITCH_NEG: begin
        rot_neg = (s1_symbol == SYM_PITCH_NEG);
        for (int i = 0; i < 3; i++) rot_q[i] = upv_e[i];
      end
      SYM_ROLL_POS, SYM_ROLL_NEG: begin
        rot_neg = (s1_symbol == SYM_ROLL_NEG);
        for (int i = 0; i < 3; i++) begin
          rot_p[i] = lft_e[i];
          rot_q[i] = upv_e[i];
        end
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    tl3d_rot_lane #(
      .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_lane (
      .p     (rot_p[g]),
      .q     (rot_q[g]),
      .c     (cos_angle),
      .s     (sin_angle),
      .neg   (rot_neg),
      .p_rot (rot_pn[g]),
      .q_rot (rot_qn[g])
    );
  end

  // ---------------------------------------------------------------- move step
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      step[i]    = ($signed({{(STEP_W-DIR_BITS){hdg_e[i][DIR_BITS-1]}}, hdg_e[i]}) <<< SHL)
                   >>> SHR;
      pos_sum[i] = {{(SUM_W-COORD_W){pos_e[i][COORD_W-1]}}, pos_e[i]}
                 + {step[i][STEP_W-1], step[i]};
      if (pos_sum[i] > POS_HI)      pos_mv[i] = POS_HI[COORD_W-1:0];
      else if (pos_sum[i] < POS_LO) pos_mv[i] = POS_LO[COORD_W-1:0];
      else                          pos_mv[i] = pos_sum[i][COORD_W-1:0];
    end
  end

  // ---------------------------------------------------------------- stack
  assign is_push = (s1_symbol == SYM_PUSH);
  assign is_pop  = (s1_symbol == SYM_POP);

  assign stk_ctl.clear = s1_done && s1_start;
  assign stk_ctl.push  = s1_done && is_push && !stk_st.full;
  assign stk_ctl.pop   = s1_done && is_pop && !stk_st.empty;

  assign push_frame = {pos_e[0], pos_e[1], pos_e[2],
                       hdg_e[0], hdg_e[1], hdg_e[2],
                       lft_e[0], lft_e[1], lft_e[2],
                       upv_e[0], upv_e[1], upv_e[2]};

  tl3d_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAME_W     (FRAME_W)
  ) u_stack (
    .clk        (clk),
    .rst        (rst),
    .ctl        (stk_ctl),
    .push_frame (push_frame),
    .st         (stk_st),
    .pop_frame  (pop_frame)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_next[i] = pos_e[i];
      hdg_next[i] = hdg_e[i];
      lft_next[i] = lft_e[i];
      upv_next[i] = upv_e[i];
    end
    fault_next = fault_flag;

    unique case (s1_symbol) inside
      SYM_YAW_POS, SYM_YAW_NEG: begin
        for (int i = 0; i < 3; i++) begin
          hdg_next[i] = rot_pn[i];
          lft_next[i] = rot_qn[i];
        end
      end
      SYM_PITCH_POS, SYM_PITCH_NEG: begin
        for (int i = 0; i < 3; i++) begin
          hdg_next[i] = rot_pn[i];
          upv_next[i] = rot_qn[i];
        end
      end
      SYM_ROLL_POS, SYM_ROLL_NEG: begin
        for (int i = 0; i < 3; i++) begin
          lft_next[i] = rot_pn[i];
          upv_next[i] = rot_qn[i];
        end
      end
      SYM_TURN: begin
        // negate with saturation: the most negative value maps to the most positive
        for (int i = 0; i < 3; i++) begin
          hdg_next[i] = (hdg_e[i] == DMIN) ? DMAX : -hdg_e[i];
          lft_next[i] = (lft_e[i] == DMIN) ? DMAX : -lft_e[i];
        end
      end
      SYM_PUSH: begin
        if (stk_st.full) fault_next = 1'b1;
      end
      SYM_POP: begin
        if (stk_st.empty) begin
          fault_next = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            pos_next[i] = pop_frame[FRAME_W-1-COORD_W*i -: COORD_W];
            hdg_next[i] = pop_frame[DIR_BITS*(9-i)-1 -: DIR_BITS];
            lft_next[i] = pop_frame[DIR_BITS*(6-i)-1 -: DIR_BITS];
            upv_next[i] = pop_frame[DIR_BITS*(3-i)-1 -: DIR_BITS];
          end
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) pos_next[i] = pos_mv[i];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        hdg[i] <= (i == 0) ? ONE : '0;
        lft[i] <= (i == 1) ? ONE : '0;
        upv[i] <= (i == 2) ? ONE : '0;
      end
      fault_flag <= 1'b0;
    end else if (s1_done) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= pos_next[i];
        hdg[i] <= hdg_next[i];
        lft[i] <= lft_next[i];
        upv[i] <= upv_next[i];
      end
      fault_flag <= fault_next;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_done && s1_emit) begin
      res_valid <= 1'b1;
    end else if (seg.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && s1_emit) begin
      for (int i = 0; i < 3; i++) begin
        res_from[i] <= pos_e[i];
        res_to[i]   <= pos_mv[i];
      end
      res_fault <= fault_flag;
    end
  end

  assign seg.valid       = res_valid;
  assign seg.from_x      = res_from[0];
  assign seg.from_y      = res_from[1];
  assign seg.from_z      = res_from[2];
  assign seg.to_x        = res_to[0];
  assign seg.to_y        = res_to[1];
  assign seg.to_z        = res_to[2];
  assign seg.stack_fault = res_fault;

  // ---------------------------------------------------------------- assertions
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    fault_flag |=> fault_flag)
    else $error("stack fault flag cleared without reset");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (s1_done && s1_emit) |=> res_valid)
    else $error("drawing move did not load the output register");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (s1_done && is_pop && stk_st.empty) |=> fault_flag)
    else $error("pop on empty stack did not raise the fault");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !seg.ready) |-> !(s1_done && s1_emit))
    else $error("pending segment overwritten");

endmodule
